@@ rtl/dle_pkg.sv @@
// ----------------------------------------------------------------------------
// dle_pkg
// Shared types and constants of the DLE frame deframer and checker.
// ----------------------------------------------------------------------------
package dle_pkg;

  localparam logic [7:0]  HdrFirst   = 8'h10;
  localparam logic [7:0]  HdrSecond  = 8'h02;
  localparam logic [7:0]  FtrFirst   = 8'h10;
  localparam logic [7:0]  FtrSecond  = 8'h03;
  localparam logic [7:0]  EscMark    = 8'h10;
  localparam logic [7:0]  EscFill    = 8'h00;
  localparam logic [7:0]  HeaderSum  = 8'h12;
  localparam logic [11:0] TallyMax   = 12'hfff;
  localparam logic [2:0]  SeenMax    = 3'd7;
  localparam logic [2:0]  BodyStart  = 3'd4;  // bytes seen when the first body byte leaves the delay line
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StShort  = 3'd1,
    StFooter = 3'd2,
    StHeader = 3'd3,
    StSum    = 3'd4
  } dle_status_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [11:0] payload_count;
  } dle_item_t;

  // up to two result words per accepted input word, compacted into slot 0 first
  typedef struct packed {
    logic      v0;
    logic      v1;
    dle_item_t i0;
    dle_item_t i1;
  } dle_push_t;

endpackage

@@ rtl/dle_if.sv @@
// ----------------------------------------------------------------------------
// dle_in_if / dle_out_if
// Valid/ready channels for raw received bytes and deframed result words.
// ----------------------------------------------------------------------------
interface dle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface dle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [11:0] payload_count;

  modport source (output valid, output out_byte, output frame_done, output frame_status,
                  output payload_count, input ready);
  modport sink   (input valid, input out_byte, input frame_done, input frame_status,
                  input payload_count, output ready);
endinterface

@@ rtl/dle_frame_deframer_checker_unit.sv @@
// ----------------------------------------------------------------------------
// dle_frame_deframer_checker_unit
// DLE deframer for RS-485 frames (10 02 ... 10 03, 10 00 escape) with an
// additive 8-bit checksum check and a per-frame status word.
//
//   channel  | dir | word                                   | per input word
//   ---------+-----+----------------------------------------+----------------
//   in_ch    | in  | rx_byte, end_of_frame                  | 1
//   out_ch   | out | out_byte, frame_done, frame_status,    | 0, 1 or 2
//            |     | payload_count                          |
//
// One input word per cycle; its results are written into a 4-entry result
// queue in the cycle it is accepted and show at out_ch the next cycle when
// the queue was empty. Input ready drops while the queue has room for fewer
// than two words, so output stalls back up to the input. A frame end yields
// the status word after any payload word. Reset is asynchronous, active low;
// the frame state returns to its start-of-frame values and the queue empties.
// ----------------------------------------------------------------------------
module dle_frame_deframer_checker_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  dle_in_if.sink    in_ch,
  dle_out_if.source out_ch
);
  import dle_pkg::*;

  logic      accept;
  logic      space;
  dle_push_t push;
  dle_item_t head;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  dle_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (in_ch.rx_byte),
    .end_of_frame_i (in_ch.end_of_frame),
    .push_o         (push)
  );

  dle_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .item_o  (head)
  );

  assign out_ch.out_byte      = head.out_byte;
  assign out_ch.frame_done    = head.frame_done;
  assign out_ch.frame_status  = head.frame_status;
  assign out_ch.payload_count = head.payload_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch.end_of_frame) |=> out_ch.valid)
    else $error("dle_unit: no result after frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.frame_done) |-> (out_ch.frame_status == StOk &&
                                              out_ch.payload_count == '0))
    else $error("dle_unit: payload word carries status fields");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.frame_done) |-> (out_ch.out_byte == '0))
    else $error("dle_unit: status word carries a byte");

endmodule

@@ rtl/dle_core.sv @@
// ----------------------------------------------------------------------------
// dle_core
// Per-byte deframing state: header check, escape removal, one-byte holdback,
// running checksum and tally, end-of-frame status.
// ----------------------------------------------------------------------------
module dle_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              end_of_frame_i,
  output dle_pkg::dle_push_t push_o
);
  import dle_pkg::*;

  logic [7:0]  dly0_q, dly1_q;
  logic [2:0]  seen_q, seen_d;
  logic        hm_q, hm_d;
  logic        esc_q, esc_d;
  logic        held_v_q, held_v_d;
  logic [7:0]  held_b_q, held_b_d;
  logic [7:0]  sum_q, sum_d;
  logic [11:0] tally_q, tally_d;

  logic        take;
  logic        emit;
  logic [7:0]  sum_byte;
  dle_status_e status;
  dle_item_t   pay_item, stat_item;

  always_comb begin
    hm_d = hm_q;
    if (seen_q == 3'd0 && rx_byte_i != HdrFirst)  hm_d = 1'b0;
    if (seen_q == 3'd1 && rx_byte_i != HdrSecond) hm_d = 1'b0;

    seen_d   = (seen_q == SeenMax) ? SeenMax : seen_q + 3'd1;
    esc_d    = esc_q;
    held_v_d = held_v_q;
    held_b_d = held_b_q;
    sum_d    = sum_q;
    tally_d  = tally_q;
    emit     = 1'b0;
    take     = 1'b0;

    // oldest raw byte leaves the delay line as a body byte
    if (seen_q >= BodyStart) begin
      take  = !(esc_q && dly1_q == EscFill);
      esc_d = take && (dly1_q == EscMark);
      if (take) begin
        if (held_v_q) begin
          sum_d   = sum_q + held_b_q;
          tally_d = (tally_q == TallyMax) ? TallyMax : tally_q + 12'd1;
          emit    = hm_d;
        end
        held_b_d = dly1_q;
        held_v_d = 1'b1;
      end
    end

    sum_byte = held_v_d ? held_b_d : 8'h00;
    if (seen_q < BodyStart)                                  status = StShort;
    else if (dly0_q != FtrFirst || rx_byte_i != FtrSecond)   status = StFooter;
    else if (!hm_d)                                          status = StHeader;
    else if (sum_byte != sum_d)                              status = StSum;
    else                                                     status = StOk;
  end

  always_comb begin
    pay_item               = '0;
    pay_item.out_byte      = held_b_q;
    stat_item              = '0;
    stat_item.frame_done   = 1'b1;
    stat_item.frame_status = status;
    stat_item.payload_count = tally_d;

    push_o.v0 = accept_i && (emit || end_of_frame_i);
    push_o.v1 = accept_i && emit && end_of_frame_i;
    push_o.i0 = emit ? pay_item : stat_item;
    push_o.i1 = stat_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly0_q   <= '0;
      dly1_q   <= '0;
      seen_q   <= '0;
      hm_q     <= 1'b1;
      esc_q    <= 1'b0;
      held_v_q <= 1'b0;
      held_b_q <= '0;
      sum_q    <= HeaderSum;
      tally_q  <= '0;
    end else if (accept_i) begin
      if (end_of_frame_i) begin
        dly0_q   <= '0;
        dly1_q   <= '0;
        seen_q   <= '0;
        hm_q     <= 1'b1;
        esc_q    <= 1'b0;
        held_v_q <= 1'b0;
        held_b_q <= '0;
        sum_q    <= HeaderSum;
        tally_q  <= '0;
      end else begin
        dly0_q   <= rx_byte_i;
        dly1_q   <= dly0_q;
        seen_q   <= seen_d;
        hm_q     <= hm_d;
        esc_q    <= esc_d;
        held_v_q <= held_v_d;
        held_b_q <= held_b_d;
        sum_q    <= sum_d;
        tally_q  <= tally_d;
      end
    end
  end

  // status word is always last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> (push_o.v0 && push_o.i1.frame_done && !push_o.i0.frame_done))
    else $error("dle_core: second slot without payload in first");
  // frame end returns to the start-of-frame state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_frame_i) |=> (seen_q == 3'd0 && sum_q == HeaderSum && !held_v_q))
    else $error("dle_core: state not cleared after frame end");
  // no payload leaves before the holdback has a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.v0 && !push_o.i0.frame_done) |-> held_v_q)
    else $error("dle_core: payload emitted with empty holdback");

endmodule

@@ rtl/dle_outq.sv @@
// ----------------------------------------------------------------------------
// dle_outq
// Small result queue: takes up to two words per cycle, delivers one while ready_i is high.
// ----------------------------------------------------------------------------
module dle_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dle_pkg::dle_push_t push_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output dle_pkg::dle_item_t item_o
);
  import dle_pkg::*;

  dle_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q;
  logic                  pop;
  logic [QueuePtrW-1:0]  wr_ptr1;
  logic [QueueCntW-1:0]  n_push;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  // room for a worst-case pair, regardless of a pop this cycle
  assign space_o = (cnt_q <= QueueCntW'(QueueDepth - 2));
  assign wr_ptr1 = wr_ptr_q + QueuePtrW'(1);
  assign n_push  = QueueCntW'(push_i.v0) + QueueCntW'(push_i.v1);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_ptr_q] <= push_i.i0;
    if (push_i.v1) mem_q[wr_ptr1]  <= push_i.i1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_push);
      if (pop) rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      cnt_q <= cnt_q + n_push - QueueCntW'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("dle_outq: occupancy beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> (cnt_q <= QueueCntW'(QueueDepth - 1)))
    else $error("dle_outq: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.v0 && !pop) |=> valid_o)
    else $error("dle_outq: pushed word not visible");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the DLE deframer and checker against a byte-level predictor. A short
// table of directed frames comes first, then random frames (well-formed, with
// damaged checksums, headers or footers, cut short, or noise) under several
// idle and stall mixes. Every output word is compared with the oldest
// expected word.
// ----------------------------------------------------------------------------
module testbench;
  import dle_pkg::*;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        eof;
    logic        typed;   // expected status word given in the row
    dle_status_e status;
    logic [11:0] count;
  } stim_row_t;

  localparam int NumRows = 27;
  localparam stim_row_t DirRows [NumRows] = '{
    // checksum mismatch, empty payload
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h02, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h13, 1'b0, 1'b0, StOk, 12'd0}, '{8'h10, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h03, 1'b1, 1'b1, StSum, 12'd0},
    // two-byte frame, too short
    '{8'hff, 1'b0, 1'b0, StOk, 12'd0}, '{8'h00, 1'b1, 1'b1, StShort, 12'd0},
    // back-to-back escapes: body 10 00 10 10 00 42
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h02, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h00, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h10, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h00, 1'b0, 1'b0, StOk, 12'd0}, '{8'h42, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h03, 1'b1, 1'b0, StOk, 12'd0},
    // bad header and bad footer: footer wins
    '{8'h00, 1'b0, 1'b0, StOk, 12'd0}, '{8'h02, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h12, 1'b0, 1'b0, StOk, 12'd0}, '{8'h10, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h02, 1'b1, 1'b1, StFooter, 12'd0},
    // bad header and bad checksum: header wins
    '{8'h10, 1'b0, 1'b0, StOk, 12'd0}, '{8'h01, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h00, 1'b0, 1'b0, StOk, 12'd0}, '{8'h10, 1'b0, 1'b0, StOk, 12'd0},
    '{8'h03, 1'b1, 1'b1, StHeader, 12'd0}
  };

  logic clk_i;
  logic rst_ni;

  dle_in_if  in_if ();
  dle_out_if out_if ();

  dle_frame_deframer_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state for the frame in progress
  logic [7:0]  line_hist [2];
  logic [2:0]  line_idx;
  logic        hdr_ok;
  logic        esc_open;
  logic        hold_v;
  logic [7:0]  hold_b;
  logic [7:0]  sum_acc;
  logic [11:0] pay_cnt;

  dle_item_t   words_due [$];
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned burst_id;

  always #5 clk_i = ~clk_i;

  function automatic void frame_restart();
    line_hist[0] = 8'h00;
    line_hist[1] = 8'h00;
    line_idx     = 3'd0;
    hdr_ok       = 1'b1;
    esc_open     = 1'b0;
    hold_v       = 1'b0;
    hold_b       = 8'h00;
    sum_acc      = HeaderSum;
    pay_cnt      = 12'd0;
  endfunction

  // one raw byte in, zero to two expected words queued
  function automatic void deframe_byte(input logic [7:0] b, input logic eof);
    logic [2:0]  idx;
    logic [7:0]  leaving;
    logic [7:0]  chk;
    dle_status_e st;
    dle_item_t   w;
    idx     = line_idx;
    leaving = line_hist[1];
    if (idx == 3'd0 && b != HdrFirst) hdr_ok = 1'b0;
    if (idx == 3'd1 && b != HdrSecond) hdr_ok = 1'b0;
    line_hist[1] = line_hist[0];
    line_hist[0] = b;
    if (idx != SeenMax) line_idx = idx + 3'd1;
    if (idx >= BodyStart) begin
      if (esc_open && leaving == EscFill) begin
        esc_open = 1'b0;
      end else begin
        esc_open = (leaving == EscMark);
        // the held byte is payload once another unescaped byte shows up
        if (hold_v) begin
          sum_acc = sum_acc + hold_b;
          if (pay_cnt != TallyMax) pay_cnt = pay_cnt + 12'd1;
          if (hdr_ok) begin
            w = '0;
            w.out_byte = hold_b;
            words_due.push_back(w);
          end
        end
        hold_b = leaving;
        hold_v = 1'b1;
      end
    end
    if (eof) begin
      chk = hold_v ? hold_b : 8'h00;
      if (idx < BodyStart) st = StShort;
      else if (line_hist[1] != FtrFirst || line_hist[0] != FtrSecond) st = StFooter;
      else if (!hdr_ok) st = StHeader;
      else if (chk != sum_acc) st = StSum;
      else st = StOk;
      w = '0;
      w.frame_done    = 1'b1;
      w.frame_status  = st;
      w.payload_count = pay_cnt;
      words_due.push_back(w);
      frame_restart();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    dle_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, byte %02h done %0b",
                                  out_if.out_byte, out_if.frame_done));
      end else begin
        want = words_due.pop_front();
        if (out_if.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_if.out_byte, want.out_byte));
        if (out_if.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %0b, want %0b",
                                    out_if.frame_done, want.frame_done));
        if (out_if.frame_status !== want.frame_status)
          report_mismatch($sformatf("frame_status %0d, want %0d",
                                    out_if.frame_status, want.frame_status));
        if (out_if.payload_count !== want.payload_count)
          report_mismatch($sformatf("payload_count %0d, want %0d",
                                    out_if.payload_count, want.payload_count));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off whenever burst_id moves
  initial begin
    int unsigned seen_burst;
    int          hold_left;
    out_if.ready = 1'b0;
    seen_burst   = 0;
    forever begin
      @(posedge clk_i);
      if (burst_id != seen_burst) begin
        seen_burst = burst_id;
        out_if.ready <= 1'b0;
        for (hold_left = 80; hold_left > 0; hold_left--) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eof);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid        <= 1'b1;
    in_if.rx_byte      <= b;
    in_if.end_of_frame <= eof;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    deframe_byte(b, eof);
  endtask

  // kind: under 60 clean, then bad sum, bad header, bad footer, cut, noise
  task automatic send_frame(input int n_pay, input int kind);
    logic [7:0] raw [$];
    logic [7:0] pay;
    logic [7:0] sum;
    int         keep;
    raw = {HdrFirst, HdrSecond};
    sum = HeaderSum;
    for (int i = 0; i < n_pay; i++) begin
      case ($urandom_range(5))
        0:       pay = EscMark;
        1:       pay = EscFill;
        2:       pay = FtrSecond;
        default: pay = 8'($urandom_range(255));
      endcase
      sum = sum + pay;
      raw.push_back(pay);
      if (pay == EscMark) raw.push_back(EscFill);
    end
    if (kind >= 60 && kind < 70) sum = sum ^ (8'h01 << $urandom_range(7));
    raw.push_back(sum);
    if (sum == EscMark) raw.push_back(EscFill);
    raw.push_back(FtrFirst);
    raw.push_back(FtrSecond);
    if (kind >= 70 && kind < 78) raw[$urandom_range(1)] = 8'($urandom_range(255));
    if (kind >= 78 && kind < 86)
      raw[raw.size() - 1 - $urandom_range(1)] = 8'($urandom_range(255));
    if (kind >= 86 && kind < 94) begin
      keep = $urandom_range(raw.size() - 1, 1);
      while (raw.size() > keep) void'(raw.pop_back());
    end
    if (kind >= 94) begin
      raw.delete();
      repeat ($urandom_range(12, 1)) raw.push_back(8'($urandom_range(255)));
    end
    foreach (raw[i]) send_word(raw[i], i == raw.size() - 1);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    dle_item_t w;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.rx_byte      = 8'h00;
    in_if.end_of_frame = 1'b0;
    mismatch_count     = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    burst_id           = 0;
    frame_restart();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      send_word(DirRows[r].rx_byte, DirRows[r].eof);
      if (DirRows[r].typed) begin
        void'(words_due.pop_back());
        w = '0;
        w.frame_done    = 1'b1;
        w.frame_status  = DirRows[r].status;
        w.payload_count = DirRows[r].count;
        words_due.push_back(w);
      end
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      for (int f = 0; f < 12; f++) begin
        // receiver holds off while words keep coming, so the input backs up
        if (ph == 0 && f == 4) burst_id++;
        send_frame(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6),
                   $urandom_range(99));
      end
      drain_results();
    end

    if (mismatch_count == 0 && words_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
